// ===== rtl/utf8_decode_width_classify_unit_macros.svh =====
// Assertion macros shared by the checker of the UTF-8 decode and width unit
`ifndef UTF8_DECODE_WIDTH_CLASSIFY_UNIT_MACROS_SVH
`define UTF8_DECODE_WIDTH_CLASSIFY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define UDWC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udwc check failed");

// Next-cycle implication, disabled while reset is high
`define UDWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udwc check failed");

`endif

// ===== rtl/udwc_pkg.sv =====
// Package: transaction types, lead byte codes and width range tables
`timescale 1ns / 1ps

package udwc_pkg;

   typedef struct packed {
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
      logic [2:0] bytes_available;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  advance;
      logic [1:0]  display_width;
      logic        regional_indicator;
   } rsp_type;

   // display width codes
   localparam logic [1:0] WIDTH_ZERO   = 2'd0;
   localparam logic [1:0] WIDTH_NARROW = 2'd1;
   localparam logic [1:0] WIDTH_WIDE   = 2'd2;

   // lead byte classes
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   localparam logic [20:0] RI_LO = 21'h1F1E6;
   localparam logic [20:0] RI_HI = 21'h1F1FF;

   typedef struct packed {
      logic [20:0] lo;
      logic [20:0] hi;
   } cp_range_type;

   localparam int ZERO_WIDTH_N = 10;
   localparam int WIDE_N       = 43;

   localparam cp_range_type ZERO_WIDTH_TAB [ZERO_WIDTH_N] = '{
      '{21'h0FE00, 21'h0FE0F}, '{21'h0200D, 21'h0200D}, '{21'h00300, 21'h0036F},
      '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF}, '{21'h020D0, 21'h020FF},
      '{21'h0FE20, 21'h0FE2F}, '{21'hE0020, 21'hE007F}, '{21'hE0100, 21'hE01EF},
      '{21'h1F3FB, 21'h1F3FF}
   };

   localparam cp_range_type WIDE_TAB [WIDE_N] = '{
      '{21'h01100, 21'h0115F}, '{21'h0231A, 21'h0231B}, '{21'h023E9, 21'h023EC},
      '{21'h023F0, 21'h023F0}, '{21'h023F3, 21'h023F3}, '{21'h025FD, 21'h025FE},
      '{21'h02614, 21'h02615}, '{21'h02648, 21'h02653}, '{21'h0267F, 21'h0267F},
      '{21'h02693, 21'h02693}, '{21'h026A1, 21'h026A1}, '{21'h026AA, 21'h026AB},
      '{21'h026BD, 21'h026BE}, '{21'h026C4, 21'h026C5}, '{21'h026CE, 21'h026CE},
      '{21'h026D4, 21'h026D4}, '{21'h026EA, 21'h026EA}, '{21'h026F2, 21'h026F3},
      '{21'h026F5, 21'h026F5}, '{21'h026FA, 21'h026FA}, '{21'h026FD, 21'h026FD},
      '{21'h02705, 21'h02705}, '{21'h0270A, 21'h0270B}, '{21'h02728, 21'h02728},
      '{21'h0274C, 21'h0274C}, '{21'h0274E, 21'h0274E}, '{21'h02753, 21'h02755},
      '{21'h02757, 21'h02757}, '{21'h02795, 21'h02797}, '{21'h027B0, 21'h027B0},
      '{21'h027BF, 21'h027BF}, '{21'h02B1B, 21'h02B1C}, '{21'h02B50, 21'h02B50},
      '{21'h02B55, 21'h02B55}, '{21'h02E80, 21'h0A4C6}, '{21'h0A960, 21'h0A97C},
      '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE10, 21'h0FE19},
      '{21'h0FE30, 21'h0FE6B}, '{21'h0FF01, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6},
      '{21'h1F000, 21'h1FFFF}
   };

endpackage

// ===== rtl/udwc_decode.sv =====
// UTF-8 decoder for one code point from a four byte window
`timescale 1ns / 1ps

module udwc_decode (
   input  udwc_pkg::req_type window,
   output logic [20:0]       code_point,
   output logic [2:0]        advance
);

   logic [7:0] b0;
   logic [5:0] c1, c2, c3;
   logic       avail_none, avail_ge2, avail_ge3, avail_ge4;

   assign b0 = window.byte_first;
   assign c1 = window.byte_second[5:0];
   assign c2 = window.byte_third[5:0];
   assign c3 = window.byte_fourth[5:0];

   // 5..7 behave as 4
   assign avail_none = (window.bytes_available == 3'd0);
   assign avail_ge2  = (window.bytes_available >= 3'd2);
   assign avail_ge3  = (window.bytes_available >= 3'd3);
   assign avail_ge4  = (window.bytes_available >= 3'd4);

   always_comb begin
      if (avail_none) begin
         code_point = 21'd0;
         advance    = 3'd0;
      end else if (!b0[7]) begin
         code_point = {13'd0, b0};
         advance    = 3'd1;
      end else if (((b0 & udwc_pkg::LEAD2_MASK) == udwc_pkg::LEAD2_CODE) && avail_ge2) begin
         code_point = {10'd0, b0[4:0], c1};
         advance    = 3'd2;
      end else if (((b0 & udwc_pkg::LEAD3_MASK) == udwc_pkg::LEAD3_CODE) && avail_ge3) begin
         code_point = {5'd0, b0[3:0], c1, c2};
         advance    = 3'd3;
      end else if (((b0 & udwc_pkg::LEAD4_MASK) == udwc_pkg::LEAD4_CODE) && avail_ge4) begin
         code_point = {b0[2:0], c1, c2, c3};
         advance    = 3'd4;
      end else begin
         // stray continuation, bad lead or truncated sequence
         code_point = {13'd0, b0};
         advance    = 3'd1;
      end
   end

endmodule

// ===== rtl/udwc_width.sv =====
// Display width and regional indicator classification of a code point
`timescale 1ns / 1ps

module udwc_width (
   input  logic [20:0] code_point,
   output logic [1:0]  display_width,
   output logic        regional_indicator
);

   logic [udwc_pkg::ZERO_WIDTH_N-1:0] zero_hit;
   logic [udwc_pkg::WIDE_N-1:0]       wide_hit;

   // all range compares in parallel, then OR-reduce
   always_comb begin
      for (int i = 0; i < udwc_pkg::ZERO_WIDTH_N; i++) begin
         zero_hit[i] = (code_point >= udwc_pkg::ZERO_WIDTH_TAB[i].lo) &&
                       (code_point <= udwc_pkg::ZERO_WIDTH_TAB[i].hi);
      end
      for (int j = 0; j < udwc_pkg::WIDE_N; j++) begin
         wide_hit[j] = (code_point >= udwc_pkg::WIDE_TAB[j].lo) &&
                       (code_point <= udwc_pkg::WIDE_TAB[j].hi);
      end
   end

   always_comb begin
      if (|zero_hit) begin
         display_width = udwc_pkg::WIDTH_ZERO;
      end else if (|wide_hit) begin
         display_width = udwc_pkg::WIDTH_WIDE;
      end else begin
         display_width = udwc_pkg::WIDTH_NARROW;
      end
   end

   assign regional_indicator = (code_point >= udwc_pkg::RI_LO) &&
                               (code_point <= udwc_pkg::RI_HI);

endmodule

// ===== rtl/utf8_decode_width_classify_unit.sv =====
// Top level: UTF-8 code point decode with terminal display width classification
//
//   Channel   Ports                          Direction  Payload
//   request   req_valid req_stall req_data   in         udwc_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data   out        udwc_pkg::rsp_type
//
// One transaction per clock sustained while rsp_stall stays low; an accepted
// request passes the input register, then the result register. Decode and
// the range compares sit between the two; the comparators set the clock limit.
// Synchronous active-high reset clears both valid flags; payload is not reset.
// rsp_stall holds the result register; req_stall rises only when both
// registers are full and the result cannot move on this cycle.
`timescale 1ns / 1ps

module utf8_decode_width_classify_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  udwc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output udwc_pkg::rsp_type rsp_data
);

   // input register
   logic              in_vld_ff, in_vld_in;
   udwc_pkg::req_type in_data_ff;

   // result register
   logic              out_vld_ff, out_vld_in;
   udwc_pkg::rsp_type out_data_ff, out_data_in;

   logic        out_move;
   logic        in_load;
   logic [20:0] dec_cp;
   logic [2:0]  dec_adv;
   logic [1:0]  cls_width;
   logic        cls_ri;

   // result slot frees when empty or being taken this cycle
   assign out_move  = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !out_move;
   assign in_load   = req_valid && !req_stall;

   udwc_decode u_decode (
      .window     (in_data_ff),
      .code_point (dec_cp),
      .advance    (dec_adv)
   );

   udwc_width u_width (
      .code_point         (dec_cp),
      .display_width      (cls_width),
      .regional_indicator (cls_ri)
   );

   always_comb begin
      out_data_in.code_point         = dec_cp;
      out_data_in.advance            = dec_adv;
      out_data_in.display_width      = cls_width;
      out_data_in.regional_indicator = cls_ri;
   end

   always_comb begin
      in_vld_in  = req_stall ? in_vld_ff : req_valid;
      out_vld_in = out_move ? in_vld_ff : out_vld_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_move && in_vld_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/udwc_checker.sv =====
// Port-level checker for the UTF-8 decode and width unit, with its bind
`timescale 1ns / 1ps
`include "utf8_decode_width_classify_unit_macros.svh"

module udwc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input udwc_pkg::rsp_type rsp_data
);

   // a held result stays put
   `UDWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data))

   // empty window: code point 0, narrow
   `UDWC_ASSERT_NOW(a_empty_window, clock, reset,
                    rsp_valid && (rsp_data.advance == 3'd0),
                    (rsp_data.code_point == 21'd0) &&
                    (rsp_data.display_width == udwc_pkg::WIDTH_NARROW))

   // single byte step carries a byte value only
   `UDWC_ASSERT_NOW(a_single_byte, clock, reset,
                    rsp_valid && (rsp_data.advance == 3'd1),
                    rsp_data.code_point[20:8] == 13'd0)

   // regional indicators need four bytes and are wide
   `UDWC_ASSERT_NOW(a_ri_wide, clock, reset,
                    rsp_valid && rsp_data.regional_indicator,
                    (rsp_data.advance == 3'd4) &&
                    (rsp_data.display_width == udwc_pkg::WIDTH_WIDE))

endmodule

bind utf8_decode_width_classify_unit udwc_checker u_udwc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
